@@ rtl/core/cpu_opcode_subset_exec_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the opcode execute block
// Shared property wrappers, clocked on the rising edge with reset disable.
// ---------------------------------------------------------------------------
`ifndef CPU_OPCODE_SUBSET_EXEC_ASSERT_SVH
`define CPU_OPCODE_SUBSET_EXEC_ASSERT_SVH

// Same-cycle implication.
`define COSE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define COSE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/cose_pkg.sv @@
// ---------------------------------------------------------------------------
// cose_pkg
// Types, widths and opcode constants shared by the opcode execute block.
// ---------------------------------------------------------------------------
package cose_pkg;

   localparam int OPCODE_W = 8;
   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int FLAG_W   = 4;

   // Flag bit positions within the flag word.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Queue between the decoder and the execute stage.
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // Byte register selectors.
   localparam logic [2:0] REG_A = 3'd0;
   localparam logic [2:0] REG_B = 3'd1;
   localparam logic [2:0] REG_C = 3'd2;
   localparam logic [2:0] REG_D = 3'd3;
   localparam logic [2:0] REG_E = 3'd4;
   localparam logic [2:0] REG_H = 3'd5;
   localparam logic [2:0] REG_L = 3'd6;

   // Register pair selectors, as coded in opcode bits 5..4.
   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_SP = 2'd3;

   // Register codes in opcode bits 5..3.
   localparam logic [2:0] CODE_L   = 3'd5;
   localparam logic [2:0] CODE_MHL = 3'd6;
   localparam logic [2:0] CODE_A   = 3'd7;

   // Whole opcodes decoded individually.
   localparam logic [OPCODE_W-1:0] OPC_NOP       = 8'h00;
   localparam logic [OPCODE_W-1:0] OPC_LD_MBC_A  = 8'h02;
   localparam logic [OPCODE_W-1:0] OPC_LD_MDE_A  = 8'h12;
   localparam logic [OPCODE_W-1:0] OPC_LD_MHL_A  = 8'h77;
   localparam logic [OPCODE_W-1:0] OPC_LD_MNN_A  = 8'hEA;
   localparam logic [OPCODE_W-1:0] OPC_LD_MNN_SP = 8'h08;
   localparam logic [OPCODE_W-1:0] OPC_RLCA      = 8'h07;
   localparam logic [OPCODE_W-1:0] OPC_INC_MHL   = 8'h34;
   localparam logic [OPCODE_W-1:0] OPC_DEC_MHL   = 8'h35;

   // Opcode groups and low-bit patterns.
   localparam logic [1:0] GRP_MISC  = 2'b00;
   localparam logic [1:0] GRP_LOAD8 = 2'b01;
   localparam logic [3:0] LO4_LD16   = 4'h1;
   localparam logic [3:0] LO4_INC16  = 4'h3;
   localparam logic [3:0] LO4_ADD_HL = 4'h9;
   localparam logic [2:0] LO3_INC8   = 3'h4;
   localparam logic [2:0] LO3_DEC8   = 3'h5;
   localparam logic [2:0] LO3_LD8    = 3'h6;
   localparam logic [2:0] LO3_SRC_A  = 3'h7;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LD16,
      OP_ST_A,
      OP_ST_A_ABS,
      OP_ST_SP,
      OP_INC16,
      OP_INC8,
      OP_DEC8,
      OP_LD8,
      OP_RLCA,
      OP_ADD_HL,
      OP_INC_M,
      OP_DEC_M,
      OP_MOV_A,
      OP_ILLEGAL
   } op_kind_type;

   typedef struct packed {
      op_kind_type         kind;
      logic [2:0]          reg_sel;
      logic [1:0]          pair_sel;
      logic [WORD_W-1:0]   immediate;
      logic [BYTE_W-1:0]   mem_read_data;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

@@ rtl/core/cose_if.sv @@
// ---------------------------------------------------------------------------
// Channel interfaces
// Request and response channels of the opcode execute block.
// ---------------------------------------------------------------------------
interface cose_req_if;
   logic                         valid;
   logic                         ready;
   logic [cose_pkg::OPCODE_W-1:0] opcode;
   logic [cose_pkg::WORD_W-1:0]   immediate;
   logic [cose_pkg::BYTE_W-1:0]   mem_read_data;

   modport source (output valid, output opcode, output immediate, output mem_read_data,
                   input ready);
   modport sink   (input valid, input opcode, input immediate, input mem_read_data,
                   output ready);
endinterface

interface cose_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         mem_write;
   logic                         mem_word;
   logic [cose_pkg::WORD_W-1:0]  mem_addr;
   logic [cose_pkg::WORD_W-1:0]  mem_data;
   logic [cose_pkg::BYTE_W-1:0]  reg_a;
   logic [cose_pkg::WORD_W-1:0]  reg_bc;
   logic [cose_pkg::WORD_W-1:0]  reg_de;
   logic [cose_pkg::WORD_W-1:0]  reg_hl;
   logic [cose_pkg::WORD_W-1:0]  reg_sp;
   logic [cose_pkg::FLAG_W-1:0]  flags_out;
   logic                         illegal_opcode;

   modport source (output valid, output mem_write, output mem_word, output mem_addr,
                   output mem_data, output reg_a, output reg_bc, output reg_de,
                   output reg_hl, output reg_sp, output flags_out, output illegal_opcode,
                   input ready);
   modport sink   (input valid, input mem_write, input mem_word, input mem_addr,
                   input mem_data, input reg_a, input reg_bc, input reg_de,
                   input reg_hl, input reg_sp, input flags_out, input illegal_opcode,
                   output ready);
endinterface

@@ rtl/core/cose_fifo.sv @@
// ---------------------------------------------------------------------------
// cose_fifo
// Short queue of decoded requests between the decoder and the execute stage.
// ---------------------------------------------------------------------------
module cose_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cose_pkg::item_type       push_item,
   input  logic                     pop,
   output cose_pkg::item_type       head_item,
   output cose_pkg::fifo_stat_type  stat
);

   cose_pkg::item_type                    store_ff [cose_pkg::FIFO_DEPTH];
   logic [cose_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [cose_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [cose_pkg::FIFO_CNT_W-1:0]       count_ff, count_in;
   logic                                  do_push, do_pop;

   localparam logic [cose_pkg::FIFO_PTR_W-1:0] LastPtr =
      cose_pkg::FIFO_PTR_W'(cose_pkg::FIFO_DEPTH - 1);
   localparam logic [cose_pkg::FIFO_CNT_W-1:0] FullCount =
      cose_pkg::FIFO_CNT_W'(cose_pkg::FIFO_DEPTH);

   assign stat.full  = (count_ff == FullCount);
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_item  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/cose_decode.sv @@
// ---------------------------------------------------------------------------
// cose_decode
// Front end: takes requests and classifies each opcode for the execute stage.
// ---------------------------------------------------------------------------
module cose_decode (
   cose_req_if.sink                 req_chan,
   input  cose_pkg::fifo_stat_type  stat,
   output logic                     push,
   output cose_pkg::item_type       push_item
);

   logic [2:0] code;
   logic [1:0] grp;
   logic [3:0] lo4;
   logic [2:0] lo3;

   assign req_chan.ready = !stat.full;
   assign push           = req_chan.valid && !stat.full;

   assign code = req_chan.opcode[5:3];
   assign grp  = req_chan.opcode[7:6];
   assign lo4  = req_chan.opcode[3:0];
   assign lo3  = req_chan.opcode[2:0];

   always_comb begin
      push_item.kind          = cose_pkg::OP_ILLEGAL;
      push_item.reg_sel       = (code == cose_pkg::CODE_A) ? cose_pkg::REG_A : code + 3'd1;
      push_item.pair_sel      = req_chan.opcode[5:4];
      push_item.immediate     = req_chan.immediate;
      push_item.mem_read_data = req_chan.mem_read_data;

      priority if (req_chan.opcode == cose_pkg::OPC_NOP) begin
         push_item.kind = cose_pkg::OP_NOP;
      end else if (req_chan.opcode == cose_pkg::OPC_LD_MBC_A ||
                   req_chan.opcode == cose_pkg::OPC_LD_MDE_A) begin
         push_item.kind = cose_pkg::OP_ST_A;
      end else if (req_chan.opcode == cose_pkg::OPC_LD_MHL_A) begin
         push_item.kind     = cose_pkg::OP_ST_A;
         push_item.pair_sel = cose_pkg::PAIR_HL;
      end else if (req_chan.opcode == cose_pkg::OPC_LD_MNN_A) begin
         push_item.kind = cose_pkg::OP_ST_A_ABS;
      end else if (req_chan.opcode == cose_pkg::OPC_LD_MNN_SP) begin
         push_item.kind = cose_pkg::OP_ST_SP;
      end else if (req_chan.opcode == cose_pkg::OPC_RLCA) begin
         push_item.kind = cose_pkg::OP_RLCA;
      end else if (req_chan.opcode == cose_pkg::OPC_INC_MHL) begin
         push_item.kind = cose_pkg::OP_INC_M;
      end else if (req_chan.opcode == cose_pkg::OPC_DEC_MHL) begin
         push_item.kind = cose_pkg::OP_DEC_M;
      end else if (grp == cose_pkg::GRP_MISC && lo4 == cose_pkg::LO4_LD16) begin
         push_item.kind = cose_pkg::OP_LD16;
      end else if (grp == cose_pkg::GRP_MISC && lo4 == cose_pkg::LO4_INC16) begin
         push_item.kind = cose_pkg::OP_INC16;
      end else if (grp == cose_pkg::GRP_MISC && lo4 == cose_pkg::LO4_ADD_HL) begin
         push_item.kind = cose_pkg::OP_ADD_HL;
      end else if (grp == cose_pkg::GRP_MISC && lo3 == cose_pkg::LO3_INC8 &&
                   code != cose_pkg::CODE_MHL) begin
         push_item.kind = cose_pkg::OP_INC8;
      end else if (grp == cose_pkg::GRP_MISC && lo3 == cose_pkg::LO3_DEC8 &&
                   code != cose_pkg::CODE_MHL) begin
         push_item.kind = cose_pkg::OP_DEC8;
      end else if (grp == cose_pkg::GRP_MISC && lo3 == cose_pkg::LO3_LD8 &&
                   code <= cose_pkg::CODE_L) begin
         push_item.kind = cose_pkg::OP_LD8;
      end else if (grp == cose_pkg::GRP_LOAD8 && lo3 == cose_pkg::LO3_SRC_A &&
                   code <= cose_pkg::CODE_L) begin
         push_item.kind = cose_pkg::OP_MOV_A;
      end else begin
         push_item.kind = cose_pkg::OP_ILLEGAL;
      end
   end

endmodule

@@ rtl/core/cose_exec.sv @@
// ---------------------------------------------------------------------------
// cose_exec
// Back end: holds the register file, executes one queued request per cycle while
// responses are taken, and drives the response register.
// ---------------------------------------------------------------------------
module cose_exec (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  cose_pkg::item_type   head_item,
   output logic                 pop,
   cose_rsp_if.source           rsp_chan
);

   localparam int BW = cose_pkg::BYTE_W;
   localparam int WW = cose_pkg::WORD_W;

   // Architectural state.
   logic [BW-1:0]               a_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff;
   logic [BW-1:0]               a_in, b_in, c_in, d_in, e_in, h_in, l_in;
   logic [WW-1:0]               sp_ff, sp_in;
   logic [cose_pkg::FLAG_W-1:0] flags_ff, flags_in;

   // Response register.
   logic                        valid_ff, valid_in;
   logic                        mem_write_ff, mem_word_ff, illegal_ff;
   logic [WW-1:0]               mem_addr_ff, mem_data_ff;

   // Datapath.
   logic                        fire;
   logic [WW-1:0]               hl, pair_val, inc16;
   logic [BW-1:0]               val8, src8, res8;
   logic                        is_dec, is_mem, half8;
   logic [WW:0]                 sum17;
   logic [12:0]                 half13;
   logic                        wr8_en, wr16_en, flags_en;
   logic [2:0]                  wr8_sel;
   logic [1:0]                  wr16_sel;
   logic [BW-1:0]               wr8_val;
   logic [WW-1:0]               wr16_val;
   logic [cose_pkg::FLAG_W-1:0] flags_new, flags_incdec, flags_add;
   logic                        mem_write, mem_word, illegal;
   logic [WW-1:0]               mem_addr, mem_data;

   assign fire = head_valid && (!valid_ff || rsp_chan.ready);
   assign pop  = fire;
   assign hl   = {h_ff, l_ff};

   always_comb begin
      unique case (head_item.reg_sel)
         cose_pkg::REG_A: val8 = a_ff;
         cose_pkg::REG_B: val8 = b_ff;
         cose_pkg::REG_C: val8 = c_ff;
         cose_pkg::REG_D: val8 = d_ff;
         cose_pkg::REG_E: val8 = e_ff;
         cose_pkg::REG_H: val8 = h_ff;
         cose_pkg::REG_L: val8 = l_ff;
         default:         val8 = '0;
      endcase
      unique case (head_item.pair_sel)
         cose_pkg::PAIR_BC: pair_val = {b_ff, c_ff};
         cose_pkg::PAIR_DE: pair_val = {d_ff, e_ff};
         cose_pkg::PAIR_HL: pair_val = hl;
         default:           pair_val = sp_ff;
      endcase
   end

   // One 8-bit increment/decrement unit, shared by register and memory forms.
   always_comb begin
      is_mem = (head_item.kind == cose_pkg::OP_INC_M) || (head_item.kind == cose_pkg::OP_DEC_M);
      is_dec = (head_item.kind == cose_pkg::OP_DEC8) || (head_item.kind == cose_pkg::OP_DEC_M);
      src8   = is_mem ? head_item.mem_read_data : val8;
      res8   = is_dec ? src8 - 8'd1 : src8 + 8'd1;
      half8  = is_dec ? (src8[3:0] == 4'h0) : (src8[3:0] == 4'hF);
      flags_incdec                   = '0;
      flags_incdec[cose_pkg::FLAG_Z] = (res8 == '0);
      flags_incdec[cose_pkg::FLAG_N] = is_dec;
      flags_incdec[cose_pkg::FLAG_H] = half8;
      flags_incdec[cose_pkg::FLAG_C] = flags_ff[cose_pkg::FLAG_C];
   end

   // 16-bit increment and HL addition.
   always_comb begin
      inc16  = pair_val + 16'd1;
      sum17  = {1'b0, hl} + {1'b0, pair_val};
      half13 = {1'b0, hl[11:0]} + {1'b0, pair_val[11:0]};
      flags_add                   = '0;
      flags_add[cose_pkg::FLAG_Z] = flags_ff[cose_pkg::FLAG_Z];
      flags_add[cose_pkg::FLAG_H] = half13[12];
      flags_add[cose_pkg::FLAG_C] = sum17[WW];
   end

   always_comb begin
      wr8_en    = 1'b0;
      wr8_sel   = head_item.reg_sel;
      wr8_val   = res8;
      wr16_en   = 1'b0;
      wr16_sel  = head_item.pair_sel;
      wr16_val  = inc16;
      flags_en  = 1'b0;
      flags_new = flags_incdec;
      mem_write = 1'b0;
      mem_word  = 1'b0;
      mem_addr  = '0;
      mem_data  = '0;
      illegal   = 1'b0;
      unique case (head_item.kind)
         cose_pkg::OP_NOP: begin
         end
         cose_pkg::OP_LD16: begin
            wr16_en  = 1'b1;
            wr16_val = head_item.immediate;
         end
         cose_pkg::OP_ST_A: begin
            mem_write = 1'b1;
            mem_addr  = pair_val;
            mem_data  = {8'h00, a_ff};
         end
         cose_pkg::OP_ST_A_ABS: begin
            mem_write = 1'b1;
            mem_addr  = head_item.immediate;
            mem_data  = {8'h00, a_ff};
         end
         cose_pkg::OP_ST_SP: begin
            mem_write = 1'b1;
            mem_word  = 1'b1;
            mem_addr  = head_item.immediate;
            mem_data  = sp_ff;
         end
         cose_pkg::OP_INC16: begin
            wr16_en = 1'b1;
         end
         cose_pkg::OP_INC8, cose_pkg::OP_DEC8: begin
            wr8_en   = 1'b1;
            flags_en = 1'b1;
         end
         cose_pkg::OP_LD8: begin
            wr8_en  = 1'b1;
            wr8_val = head_item.immediate[BW-1:0];
         end
         cose_pkg::OP_RLCA: begin
            wr8_en    = 1'b1;
            wr8_sel   = cose_pkg::REG_A;
            wr8_val   = {a_ff[BW-2:0], a_ff[BW-1]};
            flags_en  = 1'b1;
            flags_new = '0;
            flags_new[cose_pkg::FLAG_C] = a_ff[BW-1];
         end
         cose_pkg::OP_ADD_HL: begin
            wr16_en   = 1'b1;
            wr16_sel  = cose_pkg::PAIR_HL;
            wr16_val  = sum17[WW-1:0];
            flags_en  = 1'b1;
            flags_new = flags_add;
         end
         cose_pkg::OP_INC_M, cose_pkg::OP_DEC_M: begin
            flags_en  = 1'b1;
            mem_write = 1'b1;
            mem_addr  = hl;
            mem_data  = {8'h00, res8};
         end
         cose_pkg::OP_MOV_A: begin
            wr8_en  = 1'b1;
            wr8_val = a_ff;
         end
         default: begin
            illegal = 1'b1;
         end
      endcase
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      h_in     = h_ff;
      l_in     = l_ff;
      sp_in    = sp_ff;
      flags_in = flags_ff;
      if (fire && wr8_en) begin
         unique case (wr8_sel)
            cose_pkg::REG_A: a_in = wr8_val;
            cose_pkg::REG_B: b_in = wr8_val;
            cose_pkg::REG_C: c_in = wr8_val;
            cose_pkg::REG_D: d_in = wr8_val;
            cose_pkg::REG_E: e_in = wr8_val;
            cose_pkg::REG_H: h_in = wr8_val;
            cose_pkg::REG_L: l_in = wr8_val;
            default:         a_in = a_ff;
         endcase
      end
      if (fire && wr16_en) begin
         unique case (wr16_sel)
            cose_pkg::PAIR_BC: {b_in, c_in} = wr16_val;
            cose_pkg::PAIR_DE: {d_in, e_in} = wr16_val;
            cose_pkg::PAIR_HL: {h_in, l_in} = wr16_val;
            default:           sp_in        = wr16_val;
         endcase
      end
      if (fire && flags_en) begin
         flags_in = flags_new;
      end
      valid_in = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff     <= '0;
         b_ff     <= '0;
         c_ff     <= '0;
         d_ff     <= '0;
         e_ff     <= '0;
         h_ff     <= '0;
         l_ff     <= '0;
         sp_ff    <= '0;
         flags_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
         e_ff     <= e_in;
         h_ff     <= h_in;
         l_ff     <= l_in;
         sp_ff    <= sp_in;
         flags_ff <= flags_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         mem_write_ff <= mem_write;
         mem_word_ff  <= mem_word;
         mem_addr_ff  <= mem_addr;
         mem_data_ff  <= mem_data;
         illegal_ff   <= illegal;
      end
   end

   // The register file only changes when a new response is loaded, so it
   // doubles as the register part of the response.
   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.mem_write      = mem_write_ff;
   assign rsp_chan.mem_word       = mem_word_ff;
   assign rsp_chan.mem_addr       = mem_addr_ff;
   assign rsp_chan.mem_data       = mem_data_ff;
   assign rsp_chan.reg_a          = a_ff;
   assign rsp_chan.reg_bc         = {b_ff, c_ff};
   assign rsp_chan.reg_de         = {d_ff, e_ff};
   assign rsp_chan.reg_hl         = {h_ff, l_ff};
   assign rsp_chan.reg_sp         = sp_ff;
   assign rsp_chan.flags_out      = flags_ff;
   assign rsp_chan.illegal_opcode = illegal_ff;

endmodule

@@ rtl/core/cpu_opcode_subset_exec.sv @@
// ---------------------------------------------------------------------------
// cpu_opcode_subset_exec
// Executes one decoded 8-bit CPU opcode per request and reports the register
// state, flags and any memory write request that the instruction causes.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   req_chan  in         opcode, immediate, mem_read_data
//   rsp_chan  out        memory write request, A, BC, DE, HL, SP, flags, illegal
//
// One request is accepted per clock cycle for as long as responses are taken.
// An accepted request is first written into the decode queue and is then
// executed from the queue head into the response register, where its response
// appears; the execute stage sets the rate.
// Reset is synchronous and clears the registers, flags, the queue and the
// response valid flag.
// A stalled response holds the execute stage; the two-entry queue keeps
// accepting requests until it fills.
// ---------------------------------------------------------------------------
`include "cpu_opcode_subset_exec_assert.svh"

module cpu_opcode_subset_exec (
   input  logic        clock,
   input  logic        reset,
   cose_req_if.sink    req_chan,
   cose_rsp_if.source  rsp_chan
);

   // Decoded request written into the queue by the front end.
   cose_pkg::item_type      push_item;
   // Oldest queued request, seen by the execute stage.
   cose_pkg::item_type      head_item;
   // Queue occupancy status, used for back pressure and for the checks below.
   cose_pkg::fifo_stat_type fifo_stat;
   logic                    push;
   logic                    pop;

   // The front end classifies each opcode into an operation kind together
   // with its register and pair selectors; it never touches the register
   // file, so it can run ahead of the execute stage without any hazard.
   cose_decode u_decode (
      .req_chan  (req_chan),
      .stat      (fifo_stat),
      .push      (push),
      .push_item (push_item)
   );

   // The queue decouples the two halves, so that a stall on the response
   // side does not immediately stop requests from being accepted.
   cose_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (fifo_stat)
   );

   // The back end owns all architectural state and updates it in the same
   // edge that loads the response register.
   cose_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!fifo_stat.empty),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

   // A request that finds the queue empty and the response side free must
   // produce its response once it has passed the queue and the response register.
   `COSE_ASSERT_NXT(a_latency, clock, reset,
      req_chan.valid && req_chan.ready && fifo_stat.empty &&
         (!rsp_chan.valid || rsp_chan.ready),
      ##1 rsp_chan.valid,
      "request through an idle block did not respond in two cycles")

   // A response without a memory write carries an all-zero write request.
   `COSE_ASSERT_IMP(a_no_write_zero, clock, reset,
      rsp_chan.valid && !rsp_chan.mem_write,
      !rsp_chan.mem_word && rsp_chan.mem_addr == '0 && rsp_chan.mem_data == '0,
      "write request fields not cleared on a response without a write")

   // An unimplemented opcode never issues a memory write.
   `COSE_ASSERT_IMP(a_illegal_no_write, clock, reset,
      rsp_chan.valid && rsp_chan.illegal_opcode,
      !rsp_chan.mem_write,
      "illegal opcode produced a memory write")

endmodule
